/* src/gmt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gmt_pkg: shared types and constants of the grid mesh triangulator
// Payload structs of both channels, the line buffer entry and the job
// record that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package gmt_pkg;

	// Fixed field widths.
	localparam int INDEX_BITS = 24;
	localparam int COLS_BITS = 13;
	localparam int COUNT_BITS = 32;

	// Defaults and sizes.
	localparam int MAX_COLUMNS_DEF = 4096;
	localparam logic [COLS_BITS-1:0] COLS_RESET = 13'd4096;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef logic [INDEX_BITS-1:0] vidx_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	// One grid cell as it arrives.
	typedef struct packed {
		vidx_t vertex_index;
		logic  present;
		logic  first_cell;
	} cell_t;

	// One triangle as it leaves.
	typedef struct packed {
		vidx_t  corner_a;
		vidx_t  corner_b;
		vidx_t  corner_c;
		count_t triangle_number;
		logic   last_of_cell;
	} tri_t;

	// Line buffer entry.
	typedef struct packed {
		logic  present;
		vidx_t vertex_index;
	} entry_t;

	// A finished quad with at least one triangle pair to emit.
	typedef struct packed {
		vidx_t  v0;
		vidx_t  v1;
		vidx_t  v2;
		vidx_t  v3;
		logic   low;
		logic   right;
		count_t base;
	} job_t;

endpackage
`default_nettype wire

/* src/gmt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gmt_ram: generic simple dual-port RAM
// One write port, one read port with registered data. A read of the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module gmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Storage array with read-first behavior.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/gmt_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gmt_front: cell intake and quad classification
// Tracks row and column, keeps the line buffer of the previous row, and
// turns each finished quad into a job with its triangle pattern and the
// number of its first triangle.
// ----------------------------------------------------------------------------
module gmt_front #(
	parameter int MAX_COLUMNS = gmt_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cell_valid,
	output logic                                cell_ready,
	input  wire gmt_pkg::cell_t                 cell_data,
	input  wire logic                           cfg_we,
	input  wire logic [gmt_pkg::COLS_BITS-1:0]  cfg_wdata,
	output logic                                job_valid,
	input  wire logic                           job_ready,
	output gmt_pkg::job_t                       job
);

	localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CMP_W = (AW + 1 > gmt_pkg::COLS_BITS) ? AW + 1 : gmt_pkg::COLS_BITS;

	logic [gmt_pkg::COLS_BITS-1:0] cols_q;
	logic [AW-1:0]                 col_q;
	logic                          row_seen_q;
	gmt_pkg::entry_t               left_q;
	gmt_pkg::entry_t               upper_left_q;
	gmt_pkg::count_t               count_q;

	logic                          valid_s1;
	gmt_pkg::entry_t               cur_s1;
	gmt_pkg::entry_t               v1_s1;
	logic                          arm_s1;
	logic                          first_s1;

	logic                          accept;
	logic [AW-1:0]                 col_a;
	logic                          rs_a;
	logic [CMP_W-1:0]              cols_ext;
	logic [CMP_W-1:0]              eff_cols;
	logic [CMP_W-1:0]              col_inc;
	gmt_pkg::entry_t               cur_entry;
	gmt_pkg::entry_t               v3;
	logic                          fire;
	logic                          low;
	logic                          right;
	logic                          has_tri;
	logic                          go_s1;
	gmt_pkg::count_t               base;
	logic [gmt_pkg::COUNT_BITS:0]  sum;
	gmt_pkg::count_t               next_count;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= gmt_pkg::COLS_RESET;
		end else if (cfg_we) begin
			cols_q <= cfg_wdata;
		end
	end

	// Column bookkeeping for the incoming request.
	always_comb begin
		accept    = cell_valid && cell_ready;
		col_a     = cell_data.first_cell ? '0 : col_q;
		rs_a      = cell_data.first_cell ? 1'b0 : row_seen_q;
		cur_entry = '{present: cell_data.present, vertex_index: cell_data.vertex_index};
		cols_ext  = CMP_W'(cols_q);
		if (cols_ext < CMP_W'(2)) begin
			eff_cols = CMP_W'(2);
		end else if (cols_ext > CMP_W'(MAX_COLUMNS)) begin
			eff_cols = CMP_W'(MAX_COLUMNS);
		end else begin
			eff_cols = cols_ext;
		end
		col_inc = CMP_W'(col_a) + CMP_W'(1);
	end

	// Row and column position, cell to the left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_seen_q <= 1'b0;
			left_q     <= '0;
		end else if (accept) begin
			left_q <= cur_entry;
			if (col_inc >= eff_cols) begin
				col_q      <= '0;
				row_seen_q <= 1'b1;
			end else begin
				col_q      <= col_inc[AW-1:0];
				row_seen_q <= rs_a;
			end
		end
	end

	// Line buffer: the old entry is read while the new cell replaces it.
	gmt_ram #(
		.WIDTH ($bits(gmt_pkg::entry_t)),
		.DEPTH (MAX_COLUMNS)
	) u_line (
		.clk   (clk),
		.we    (accept),
		.waddr (col_a),
		.wdata (cur_entry),
		.re    (accept),
		.raddr (col_a),
		.rdata (v3)
	);

	// Stage 1 register, loaded with each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cell_ready) begin
			valid_s1 <= cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1   <= cur_entry;
			v1_s1    <= left_q;
			arm_s1   <= rs_a && (col_a != '0);
			first_s1 <= cell_data.first_cell;
		end
	end

	// Quad classification with the line buffer data.
	always_comb begin
		fire    = arm_s1 && upper_left_q.present;
		low     = fire && v1_s1.present && cur_s1.present;
		right   = fire && cur_s1.present && v3.present;
		has_tri = low || right;
		go_s1   = valid_s1 && (!has_tri || job_ready);
		base    = first_s1 ? '0 : count_q;
		sum     = {1'b0, base} + ((low && right) ? (gmt_pkg::COUNT_BITS + 1)'(4)
		                                          : (gmt_pkg::COUNT_BITS + 1)'(2));
		if (!has_tri) begin
			next_count = base;
		end else if (sum[gmt_pkg::COUNT_BITS]) begin
			next_count = gmt_pkg::COUNT_MAX;
		end else begin
			next_count = sum[gmt_pkg::COUNT_BITS-1:0];
		end
		cell_ready = !valid_s1 || go_s1;
		job_valid  = valid_s1 && has_tri;
		job        = '{v0: upper_left_q.vertex_index, v1: v1_s1.vertex_index,
		               v2: cur_s1.vertex_index, v3: v3.vertex_index,
		               low: low, right: right, base: base};
	end

	// Upper-left cell and running triangle count advance as stage 1 drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_left_q <= '0;
			count_q      <= '0;
		end else if (go_s1) begin
			upper_left_q <= v3;
			count_q      <= next_count;
		end
	end

`ifndef SYNTHESIS
	// A new grid always starts at column one of the first row afterwards.
	a_first_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cell_data.first_cell |=> (col_q == AW'(1)) && !row_seen_q)
		else $error("first cell did not restart the grid position");

	// No triangles in the first row or the first column.
	a_no_edge_tri: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !arm_s1 |-> !job_valid)
		else $error("triangle produced on the grid edge");
`endif

endmodule
`default_nettype wire

/* src/gmt_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gmt_queue: short job queue between front and back
// A small register FIFO so that the intake and the triangle emitter
// stall independently.
// ----------------------------------------------------------------------------
module gmt_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire gmt_pkg::job_t push_job,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output gmt_pkg::job_t      pop_job
);

	localparam int DEPTH = gmt_pkg::QUEUE_DEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	gmt_pkg::job_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          push;
	logic          pop;

	// Handshake decode.
	always_comb begin
		push_ready = (fill_q != CW'(DEPTH));
		pop_valid  = (fill_q != '0);
		push       = push_valid && push_ready;
		pop        = pop_valid && pop_ready;
		pop_job    = slot_q[rd_ptr_q];
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	// The fill level never exceeds the depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("queue fill level out of range");

	// Pointers stay consistent with the fill level.
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with mismatched pointers");
`endif

endmodule
`default_nettype wire

/* src/gmt_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gmt_back: triangle emitter
// Walks the triangles of the job at the queue head into the output
// register, one per cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
module gmt_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire gmt_pkg::job_t job,
	output logic               tri_valid,
	input  wire logic          tri_ready,
	output gmt_pkg::tri_t      tri_data
);

	logic                         tri_valid_q;
	gmt_pkg::tri_t                tri_q;
	logic [1:0]                   k_q;
	logic                         both;
	logic [1:0]                   slot;
	logic                         last;
	logic                         load;
	logic [gmt_pkg::COUNT_BITS:0] sum;
	gmt_pkg::tri_t                next_tri;

	// Triangle selection for the current step of the head job.
	always_comb begin
		both = job.low && job.right;
		slot = both ? k_q : {k_q[0], ~job.low};
		last = both ? (k_q == 2'd3) : (k_q == 2'd1);
		load = job_valid && (!tri_valid_q || tri_ready);
		job_ready = load && last;
		sum = {1'b0, job.base} + (gmt_pkg::COUNT_BITS + 1)'(k_q);
		next_tri.corner_a = job.v0;
		next_tri.last_of_cell = last;
		next_tri.triangle_number = sum[gmt_pkg::COUNT_BITS] ? gmt_pkg::COUNT_MAX
		                                                     : sum[gmt_pkg::COUNT_BITS-1:0];
		unique case (slot)
			2'd0: begin
				next_tri.corner_b = job.v2;
				next_tri.corner_c = job.v1;
			end
			2'd1: begin
				next_tri.corner_b = job.v3;
				next_tri.corner_c = job.v2;
			end
			2'd2: begin
				next_tri.corner_b = job.v1;
				next_tri.corner_c = job.v2;
			end
			default: begin
				next_tri.corner_b = job.v2;
				next_tri.corner_c = job.v3;
			end
		endcase
	end

	// Output register and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (load) begin
				tri_valid_q <= 1'b1;
				k_q         <= last ? 2'd0 : k_q + 2'd1;
			end else if (tri_ready) begin
				tri_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tri_q <= next_tri;
		end
	end

	assign tri_valid = tri_valid_q;
	assign tri_data  = tri_q;

`ifndef SYNTHESIS
	// A quad's triangles follow each other with consecutive numbers.
	a_number_step: assert property (@(posedge clk) disable iff (!arst_n)
		tri_valid_q && tri_ready && !tri_q.last_of_cell |=> tri_valid_q &&
		((tri_q.triangle_number == $past(tri_q.triangle_number) + 32'd1) ||
		 (tri_q.triangle_number == gmt_pkg::COUNT_MAX)))
		else $error("triangle number did not advance within a quad");

	// All triangles of a quad share the top-left corner.
	a_same_quad: assert property (@(posedge clk) disable iff (!arst_n)
		tri_valid_q && tri_ready && !tri_q.last_of_cell |=>
		tri_q.corner_a == $past(tri_q.corner_a))
		else $error("quad changed before its last triangle");
`endif

endmodule
`default_nettype wire

/* src/grid_mesh_triangulator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grid_mesh_triangulator: heightmap grid to triangle index list
// Turns a raster-order grid of vertex indices into up to four triangles
// per finished quad, numbered in output order.
// ----------------------------------------------------------------------------
// Usage:
// Cells arrive on cell_valid/cell_ready/cell_data, one request per cell in
// raster order; first_cell starts a new grid. Triangles leave on
// tri_valid/tri_ready/tri_data, last_of_cell marking the final triangle of
// a cell. cfg_we/cfg_wdata set the row width while the block is idle.
// A cell is taken every cycle while the job queue has room; cells that
// yield nothing send no job. The first triangle of a cell passes the
// stage 1 register, the job queue and the output register. Triangles
// leave at one per cycle while the receiver is ready, and a full quad
// yields four; that output register sets the sustained rate.
// Reset clears the position, the triangle count and all queues and sets
// the row width to 4096; the line buffer needs no clearing. A stalled
// receiver holds the current triangle; the job queue then fills and the
// intake stops taking cells once a cell that yields triangles waits.
// ----------------------------------------------------------------------------
module grid_mesh_triangulator #(
	parameter int MAX_COLUMNS = gmt_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cell_valid,
	output logic                               cell_ready,
	input  wire gmt_pkg::cell_t                cell_data,
	output logic                               tri_valid,
	input  wire logic                          tri_ready,
	output gmt_pkg::tri_t                      tri_data,
	input  wire logic                          cfg_we,
	input  wire logic [gmt_pkg::COLS_BITS-1:0] cfg_wdata
);

	logic          fq_valid;
	logic          fq_ready;
	gmt_pkg::job_t fq_job;
	logic          qb_valid;
	logic          qb_ready;
	gmt_pkg::job_t qb_job;

	// Intake and classification.
	gmt_front #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_data  (cell_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.job_valid  (fq_valid),
		.job_ready  (fq_ready),
		.job        (fq_job)
	);

	// Decoupling queue.
	gmt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	// Triangle emitter.
	gmt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.tri_valid (tri_valid),
		.tri_ready (tri_ready),
		.tri_data  (tri_data)
	);

endmodule
`default_nettype wire

/* tb/gmt_checker.sv */
// ----------------------------------------------------------------------------
// gmt_checker: triangle predictor and scoreboard for grid_mesh_triangulator
// Watches the configuration port and both request channels. Every accepted
// cell runs through a local model of the line buffer and the quad logic.
// The triangles that the model produces queue up in order. Every accepted
// triangle is compared field by field with the oldest one in that queue.
// ----------------------------------------------------------------------------
module gmt_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cell_valid,
	input  wire logic                          cell_ready,
	input  wire gmt_pkg::cell_t                cell_data,
	input  wire logic                          tri_valid,
	input  wire logic                          tri_ready,
	input  wire gmt_pkg::tri_t                 tri_data,
	input  wire logic                          cfg_we,
	input  wire logic [gmt_pkg::COLS_BITS-1:0] cfg_wdata,
	output int                                 fail_count,
	output int                                 pending_count,
	output int                                 cells_seen,
	output int                                 tris_seen
);
	import gmt_pkg::*;

	localparam int COLUMNS = MAX_COLUMNS_DEF;
	localparam int REPORT_LIMIT = 10;

	// Local copy of the block's grid state.
	entry_t               line_store [COLUMNS];
	entry_t               left_entry;
	entry_t               upper_left_entry;
	int                   column_pos;
	logic                 full_row_seen;
	count_t               tri_count;
	logic [COLS_BITS-1:0] width_reg;

	// Triangles predicted but not yet seen on the output.
	tri_t expected_tris[$];

	// Number the next triangle; the count sticks at its maximum.
	function automatic tri_t number_triangle(vidx_t a, vidx_t b, vidx_t c);
		tri_t t;
		t.corner_a = a;
		t.corner_b = b;
		t.corner_c = c;
		t.triangle_number = tri_count;
		t.last_of_cell = 1'b0;
		if (tri_count != COUNT_MAX) begin
			tri_count++;
		end
		return t;
	endfunction

	// Advance the grid by one cell and queue the triangles it completes.
	function automatic void predict_cell(cell_t c);
		entry_t cur;
		entry_t v0;
		entry_t v1;
		entry_t v3;
		tri_t   batch [4];
		int     n;
		int     col;
		int     cols;
		logic   low;
		logic   right;
		cur.present = c.present;
		cur.vertex_index = c.vertex_index;
		n = 0;
		if (c.first_cell) begin
			column_pos = 0;
			full_row_seen = 1'b0;
			tri_count = '0;
		end
		col = column_pos;
		if (col >= COLUMNS) begin
			col = 0;
		end
		v0 = upper_left_entry;
		v1 = left_entry;
		v3 = line_store[col];

		// The new cell closes the quad to its upper left.
		if (full_row_seen && col >= 1 && v0.present) begin
			low = v1.present && cur.present;
			right = cur.present && v3.present;
			if (low) begin
				batch[n++] = number_triangle(v0.vertex_index, cur.vertex_index,
					v1.vertex_index);
			end
			if (right) begin
				batch[n++] = number_triangle(v0.vertex_index, v3.vertex_index,
					cur.vertex_index);
			end
			if (low) begin
				batch[n++] = number_triangle(v0.vertex_index, v1.vertex_index,
					cur.vertex_index);
			end
			if (right) begin
				batch[n++] = number_triangle(v0.vertex_index, cur.vertex_index,
					v3.vertex_index);
			end
			if (n > 0) begin
				batch[n-1].last_of_cell = 1'b1;
			end
			for (int i = 0; i < n; i++) begin
				expected_tris.push_back(batch[i]);
			end
		end

		upper_left_entry = v3;
		line_store[col] = cur;
		left_entry = cur;

		// Width values out of range are clamped; a narrower width wraps at once.
		cols = width_reg;
		if (cols < 2) begin
			cols = 2;
		end
		if (cols > COLUMNS) begin
			cols = COLUMNS;
		end
		col++;
		if (col >= cols) begin
			col = 0;
			full_row_seen = 1'b1;
		end
		column_pos = col;
	endfunction

	// Count a failure and show the first few in detail.
	task automatic report_failure(string what, tri_t want, tri_t got);
		if (fail_count < REPORT_LIMIT) begin
			$display("%s: expected a=%h b=%h c=%h n=%0d last=%b", what,
				want.corner_a, want.corner_b, want.corner_c,
				want.triangle_number, want.last_of_cell);
			$display("    got      a=%h b=%h c=%h n=%0d last=%b",
				got.corner_a, got.corner_b, got.corner_c,
				got.triangle_number, got.last_of_cell);
		end
		fail_count++;
	endtask

	// Compare one accepted triangle with the oldest prediction.
	task automatic check_triangle(tri_t got);
		tri_t want;
		if (expected_tris.size() == 0) begin
			report_failure("Triangle with none expected", '0, got);
		end else begin
			want = expected_tris.pop_front();
			if (got.corner_a !== want.corner_a || got.corner_b !== want.corner_b ||
				got.corner_c !== want.corner_c ||
				got.triangle_number !== want.triangle_number ||
				got.last_of_cell !== want.last_of_cell) begin
				report_failure("Triangle mismatch", want, got);
			end
		end
	endtask

	// Follow the register and both channels at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COLUMNS; i++) begin
				line_store[i] = '0;
			end
			left_entry = '0;
			upper_left_entry = '0;
			column_pos = 0;
			full_row_seen = 1'b0;
			tri_count = '0;
			width_reg = COLS_RESET;
			expected_tris.delete();
			fail_count = 0;
			cells_seen = 0;
			tris_seen = 0;
		end else begin
			if (cfg_we) begin
				width_reg = cfg_wdata;
			end
			if (cell_valid && cell_ready) begin
				predict_cell(cell_data);
				cells_seen++;
			end
			if (tri_valid && tri_ready) begin
				check_triangle(tri_data);
				tris_seen++;
			end
		end
		pending_count = expected_tris.size();
	end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for grid_mesh_triangulator
// Drives grids of cells at several row widths: a directed grid with a full
// quad and each lone missing corner, then random grids with random gaps on
// both sides, a long output stall, a width change in mid-row and one grid
// at the full width. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module tb_top;
	import gmt_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 6;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int WATCHDOG_LIMIT = 3000;

	logic                 clk;
	logic                 arst_n;
	logic                 cell_valid;
	logic                 cell_ready;
	cell_t                cell_data;
	logic                 tri_valid;
	logic                 tri_ready;
	tri_t                 tri_data;
	logic                 cfg_we;
	logic [COLS_BITS-1:0] cfg_wdata;

	int fail_count;
	int pending_count;
	int cells_seen;
	int tris_seen;
	int widths_run;
	bit tx_idle;
	bit rx_idle;
	bit hold_off_req;

	grid_mesh_triangulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_valid(cell_valid),
		.cell_ready(cell_ready),
		.cell_data (cell_data),
		.tri_valid (tri_valid),
		.tri_ready (tri_ready),
		.tri_data  (tri_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	gmt_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cell_valid   (cell_valid),
		.cell_ready   (cell_ready),
		.cell_data    (cell_data),
		.tri_valid    (tri_valid),
		.tri_ready    (tri_ready),
		.tri_data     (tri_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.pending_count(pending_count),
		.cells_seen   (cells_seen),
		.tris_seen    (tris_seen)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Idle stretch length: mostly short, now and then long.
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic cell_t grid_cell(vidx_t idx, logic p, logic f);
		cell_t c;
		c.vertex_index = idx;
		c.present = p;
		c.first_cell = f;
		return c;
	endfunction

	// Random cell with extreme indices now and then.
	function automatic cell_t random_cell(logic restart);
		cell_t c;
		int    roll;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			c.vertex_index = '0;
		end else if (roll < 16) begin
			c.vertex_index = '1;
		end else begin
			c.vertex_index = vidx_t'($urandom());
		end
		c.present = ($urandom_range(0, 99) < 85);
		c.first_cell = restart;
		return c;
	endfunction

	// Offer one cell and hold it until it is taken. Starts and ends at a
	// falling edge with valid still high.
	task automatic send_cell(input cell_t c);
		int gap;
		gap = (tx_idle && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cell_valid <= 1'b1;
		cell_data <= c;
		@(posedge clk);
		while (!cell_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop sending and wait until every predicted triangle has left.
	task automatic finish_phase();
		cell_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_columns(input logic [COLS_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		widths_run++;
	endtask

	// One random grid. The first cell always starts a new grid, so a wider
	// setting never reads line buffer entries left from an older grid.
	task automatic run_grid(input logic [COLS_BITS-1:0] width_value, input int cells,
		input bit tx, input bit rx, input int restart_pct, input bit squeeze,
		input int shrink_at, input logic [COLS_BITS-1:0] shrink_value);
		tx_idle = tx;
		rx_idle = rx;
		write_columns(width_value);
		for (int i = 0; i < cells; i++) begin
			if (shrink_at != 0 && i == shrink_at) begin
				finish_phase();
				write_columns(shrink_value);
			end
			if (squeeze && i == 16) begin
				hold_off_req = 1'b1;
			end
			send_cell(random_cell(i == 0 || $urandom_range(0, 99) < restart_pct));
		end
		finish_phase();
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		tri_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end else if (stall_left == 0 && rx_idle && $urandom_range(0, 99) < 30) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				tri_ready <= 1'b0;
				stall_left--;
			end else begin
				tri_ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any request moving on either channel.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cell_valid && cell_ready) || (tri_valid && tri_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("** grid_mesh_triangulator: FAILED **");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		cell_valid = 1'b0;
		cell_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_off_req = 1'b0;
		widths_run = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed grid, two columns (a zero width acts as two).
		write_columns('0);
		send_cell(grid_cell(24'h000000, 1'b1, 1'b1));
		send_cell(grid_cell(24'hFFFFFF, 1'b1, 1'b0));
		// All four corners present.
		send_cell(grid_cell(24'h000001, 1'b1, 1'b0));
		send_cell(grid_cell(24'h000002, 1'b1, 1'b0));
		// Lower-left missing: only the right pair.
		send_cell(grid_cell(24'h000003, 1'b0, 1'b0));
		send_cell(grid_cell(24'h000004, 1'b1, 1'b0));
		// Top-left missing: nothing.
		send_cell(grid_cell(24'h000005, 1'b1, 1'b0));
		send_cell(grid_cell(24'h000006, 1'b1, 1'b0));
		// Full quad again with high indices.
		send_cell(grid_cell(24'h000007, 1'b1, 1'b0));
		send_cell(grid_cell(24'hFFFFFE, 1'b1, 1'b0));
		// Lower-right missing: nothing.
		send_cell(grid_cell(24'h000008, 1'b1, 1'b0));
		send_cell(grid_cell(24'h000009, 1'b0, 1'b0));
		// Upper-right missing: only the low pair.
		send_cell(grid_cell(24'hFFFFFF, 1'b1, 1'b0));
		send_cell(grid_cell(24'h000000, 1'b1, 1'b0));
		// New grid at the start of a row; the count starts over.
		send_cell(grid_cell(24'h00000A, 1'b1, 1'b1));
		send_cell(grid_cell(24'h00000B, 1'b1, 1'b0));
		send_cell(grid_cell(24'h00000C, 1'b1, 1'b0));
		send_cell(grid_cell(24'h00000D, 1'b1, 1'b0));
		// New grid in mid-row.
		send_cell(grid_cell(24'h00000E, 1'b1, 1'b0));
		send_cell(grid_cell(24'h00000F, 1'b1, 1'b1));
		send_cell(grid_cell(24'h000010, 1'b1, 1'b0));
		send_cell(grid_cell(24'h000011, 1'b1, 1'b0));
		send_cell(grid_cell(24'h000012, 1'b1, 1'b0));
		finish_phase();

		// Random grids.
		run_grid(13'd2, 40, 1'b1, 1'b1, 2, 1'b0, 0, '0);
		run_grid(13'd3, 60, 1'b1, 1'b1, 2, 1'b0, 0, '0);
		// Sender keeps offering while the receiver holds off.
		run_grid(13'd7, 70, 1'b0, 1'b1, 0, 1'b1, 0, '0);
		// Narrower width written in the middle of the third row.
		run_grid(13'd16, 70, 1'b1, 1'b1, 0, 1'b0, 40, 13'd5);
		run_grid(13'd4, 60, 1'b0, 1'b0, 2, 1'b0, 0, '0);
		// All ones acts as the full width; a short stretch of the first row.
		run_grid('1, 20, 1'b1, 1'b1, 0, 1'b0, 0, '0);
		run_grid(13'd1, 50, 1'b1, 1'b1, 3, 1'b0, 0, '0);
		run_grid(13'd11, 40, 1'b1, 1'b1, 1, 1'b0, 0, '0);

		$display("Checked %0d cells and %0d triangles over %0d width settings,",
			cells_seen, tris_seen, widths_run);
		$display("with random gaps, a %0d-cycle output stall and a mid-row width change.",
			HOLD_OFF_CYCLES);
		if (fail_count == 0 && pending_count == 0) begin
			$display("** grid_mesh_triangulator: PASSED **");
		end else begin
			$display("** grid_mesh_triangulator: FAILED **");
		end
		$finish;
	end

endmodule
